// ===== rtl/ptrk_pkg.sv =====
// Shared types, constants and the arctangent table for the polar tracker.
package ptrk_pkg;

	localparam int CORDIC_ITERATIONS = 16;
	localparam int ITER_W            = 5;
	localparam int SQRT_STEPS        = 16;
	localparam int STEP_W            = 4;
	localparam int CW                = 56;
	localparam int ZW                = 26;
	localparam int TW                = 22;

	localparam logic signed [ZW-1:0] HALF_TURN = 26'sd8388608;
	localparam logic [15:0]          TIME_STEP_RESET = 16'd655;

	localparam logic REG_TIME_STEP = 1'b0;
	localparam logic REQ_FIRST     = 1'b0;
	localparam logic REQ_NEXT      = 1'b1;

	typedef struct packed {
		logic                 valid;
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [ZW-1:0] z;
	} cordic_stage_t;

	typedef struct packed {
		logic        valid;
		logic [31:0] n;
		logic [31:0] r;
	} sqrt_stage_t;

	// atan(2^-i) in units of 2^24 per turn
	function automatic logic [TW-1:0] atan_lut(input logic [ITER_W-1:0] idx);
		logic [TW-1:0] v;
		case (idx)
			5'd0:    v = 22'd2097152;
			5'd1:    v = 22'd1238021;
			5'd2:    v = 22'd654136;
			5'd3:    v = 22'd332050;
			5'd4:    v = 22'd166669;
			5'd5:    v = 22'd83416;
			5'd6:    v = 22'd41718;
			5'd7:    v = 22'd20860;
			5'd8:    v = 22'd10430;
			5'd9:    v = 22'd5215;
			5'd10:   v = 22'd2608;
			5'd11:   v = 22'd1304;
			5'd12:   v = 22'd652;
			5'd13:   v = 22'd326;
			5'd14:   v = 22'd163;
			5'd15:   v = 22'd81;
			5'd16:   v = 22'd41;
			5'd17:   v = 22'd20;
			5'd18:   v = 22'd10;
			5'd19:   v = 22'd5;
			5'd20:   v = 22'd3;
			5'd21:   v = 22'd1;
			5'd22:   v = 22'd1;
			default: v = 22'd0;
		endcase
		return v;
	endfunction

endpackage

// ===== rtl/polar_tracker_with_unwrapped_angle.sv =====
// Top level: Cartesian points in, radius and unwrapped angle out.
//
// Input channel (in_valid/in_ready) carries one point per transaction: req_type
// selects the first point of a new curve or the next point, point_x/point_y are
// signed Q3.12, start_time loads the curve time on a first point.
// Output channel (out_valid/out_ready) returns one transaction per point:
// radius (Q3.12, rounded), angle (65536 units per turn, unwrapped, wraps at
// 32 bits) and next_time (curve time after this point).
// The time_step register sits at byte address 0 of the APB-style port.
// A point passes the point latch, the products, the sums, the scale and fold
// register, the row of CORDIC cells (one rotation step per cell), the capture
// registers and the output register; a row of 16 square-root cells runs beside
// the CORDIC row. One point is in flight at a time, so a new point is taken
// only after the last one has moved into the output register.
// in_ready drops while a point is in flight and returns as soon as its result
// moves into the output register, so the next point can start while the
// receiver still stalls. A result that cannot leave holds in the cell rows'
// capture registers until the output register frees up.
// Reset clears the previous point, the angle and the curve time to zero and
// loads time_step with 655.
module polar_tracker_with_unwrapped_angle import ptrk_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               req_type,
	input  logic signed [15:0] point_x,
	input  logic signed [15:0] point_y,
	input  logic [31:0]        start_time,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [15:0]        radius,
	output logic signed [31:0] angle,
	output logic [31:0]        next_time
);

	// Configuration
	logic [15:0] time_step_q;
	logic        cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_TIME_STEP);
	assign prdata = (paddr[2] == REG_TIME_STEP) ? {16'd0, time_step_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_step_q <= TIME_STEP_RESET;
		end else if (cfg_wr) begin
			time_step_q <= pwdata[15:0];
		end
	end

	// Tracker state and control
	logic               busy_q;
	logic               accept;
	logic signed [15:0] prev_x_q, prev_y_q;
	logic               prev_nz_q;
	logic [31:0]        acc_q, time_q;
	logic               cur_nz, first_in, en_in;

	assign in_ready = !busy_q;
	assign accept   = in_valid && in_ready;
	assign cur_nz   = (point_x != '0) || (point_y != '0);
	assign first_in = (req_type == REQ_FIRST);
	// A first point takes an angle only when x is positive or y is negative; a
	// next point only when both radii are nonzero.
	assign en_in    = first_in ? ((!point_x[15] && (point_x != '0)) || point_y[15])
	                           : (cur_nz && prev_nz_q);

	// Point latch, held for the whole transaction
	logic               first_q, en_q;
	logic [31:0]        start_q;
	logic signed [15:0] x_s1, y_s1, px_s1, py_s1;
	logic               v_s1, v_s2, v_s3, v_s4;

	always_ff @(posedge clk) begin
		if (accept) begin
			first_q <= first_in;
			en_q    <= en_in;
			start_q <= start_time;
			x_s1    <= point_x;
			y_s1    <= point_y;
			px_s1   <= prev_x_q;
			py_s1   <= prev_y_q;
		end
	end

	// Products
	logic signed [31:0] xx_s2, yy_s2, pxy_s2, pyx_s2, pxx_s2, pyy_s2;

	always_ff @(posedge clk) begin
		if (v_s1) begin
			xx_s2  <= x_s1 * x_s1;
			yy_s2  <= y_s1 * y_s1;
			pxy_s2 <= px_s1 * y_s1;
			pyx_s2 <= py_s1 * x_s1;
			pxx_s2 <= px_s1 * x_s1;
			pyy_s2 <= py_s1 * y_s1;
		end
	end

	// Sums and operand selection
	logic [31:0] sum_s3;
	logic [32:0] cx_s3, cy_s3;
	logic [32:0] cross_w, dot_w;

	assign cross_w = {pxy_s2[31], pxy_s2} - {pyx_s2[31], pyx_s2};
	assign dot_w   = {pxx_s2[31], pxx_s2} + {pyy_s2[31], pyy_s2};

	always_ff @(posedge clk) begin
		if (v_s2) begin
			sum_s3 <= xx_s2 + yy_s2;
			cx_s3  <= first_q ? {{17{x_s1[15]}}, x_s1} : dot_w;
			cy_s3  <= first_q ? {{17{y_s1[15]}}, y_s1} : cross_w;
		end
	end

	// Scale by 2^20 and fold the left half-plane over by a half turn
	logic signed [CW-1:0] xe, ye, x_s4, y_s4;
	logic signed [ZW-1:0] z_s4;

	assign xe = {{(CW-53){cx_s3[32]}}, cx_s3, 20'd0};
	assign ye = {{(CW-53){cy_s3[32]}}, cy_s3, 20'd0};

	always_ff @(posedge clk) begin
		if (v_s3) begin
			if (cx_s3[32]) begin
				x_s4 <= -xe;
				y_s4 <= -ye;
				z_s4 <= cy_s3[32] ? -HALF_TURN : HALF_TURN;
			end else begin
				x_s4 <= xe;
				y_s4 <= ye;
				z_s4 <= '0;
			end
		end
	end

	// Cell rows
	cordic_stage_t co [0:CORDIC_ITERATIONS];
	sqrt_stage_t   sq [0:SQRT_STEPS];

	assign co[0] = '{valid: v_s4, x: x_s4, y: y_s4, z: z_s4};
	assign sq[0] = '{valid: v_s3, n: sum_s3, r: 32'd0};

	for (genvar g = 0; g < CORDIC_ITERATIONS; g++) begin : g_cordic
		ptrk_cordic_cell u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.d     (co[g]),
			.iter  (ITER_W'(g)),
			.q     (co[g+1])
		);
	end

	for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_sqrt
		ptrk_sqrt_cell u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.d     (sq[g]),
			.step  (STEP_W'(g)),
			.q     (sq[g+1])
		);
	end

	// Capture the row outputs: round the angle to output units, round the root
	logic signed [ZW-1:0] z_rnd;
	logic [31:0]          inc_q;
	logic [15:0]          rad_q;
	logic                 co_done_q, sq_done_q;
	logic                 fin;

	assign z_rnd = co[CORDIC_ITERATIONS].z + ZW'(128);

	always_ff @(posedge clk) begin
		if (co[CORDIC_ITERATIONS].valid) begin
			inc_q <= en_q ? {{(40-ZW){z_rnd[ZW-1]}}, z_rnd[ZW-1:8]} : 32'd0;
		end
		if (sq[SQRT_STEPS].valid) begin
			rad_q <= sq[SQRT_STEPS].r[15:0]
			         + 16'(sq[SQRT_STEPS].n > sq[SQRT_STEPS].r);
		end
	end

	// Finish: accumulate, advance time, load the output register
	logic [31:0] acc_nx, time_nx;
	logic        out_valid_q;
	logic [15:0] radius_q;
	logic [31:0] angle_q, next_time_q;

	assign fin     = co_done_q && sq_done_q && (!out_valid_q || out_ready);
	assign acc_nx  = first_q ? inc_q : acc_q + inc_q;
	assign time_nx = first_q ? start_q : time_q + {16'd0, time_step_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			prev_x_q    <= '0;
			prev_y_q    <= '0;
			prev_nz_q   <= 1'b0;
			acc_q       <= '0;
			time_q      <= '0;
			co_done_q   <= 1'b0;
			sq_done_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			if (accept) begin
				// Advance the stored point now; the latch keeps the old one
				busy_q    <= 1'b1;
				prev_x_q  <= point_x;
				prev_y_q  <= point_y;
				prev_nz_q <= cur_nz;
			end
			if (fin) begin
				busy_q      <= 1'b0;
				acc_q       <= acc_nx;
				time_q      <= time_nx;
				co_done_q   <= 1'b0;
				sq_done_q   <= 1'b0;
				out_valid_q <= 1'b1;
			end else begin
				if (co[CORDIC_ITERATIONS].valid) begin
					co_done_q <= 1'b1;
				end
				if (sq[SQRT_STEPS].valid) begin
					sq_done_q <= 1'b1;
				end
				if (out_ready) begin
					out_valid_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fin) begin
			radius_q    <= rad_q;
			angle_q     <= acc_nx;
			next_time_q <= time_nx;
		end
	end

	assign out_valid = out_valid_q;
	assign radius    = radius_q;
	assign angle     = angle_q;
	assign next_time = next_time_q;

endmodule

// ===== rtl/ptrk_cordic_cell.sv =====
// One vectoring CORDIC step with its output register.
module ptrk_cordic_cell import ptrk_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  cordic_stage_t     d,
	input  logic [ITER_W-1:0] iter,
	output cordic_stage_t     q
);

	logic                 valid_q;
	logic signed [CW-1:0] x_q, y_q;
	logic signed [ZW-1:0] z_q;
	logic signed [CW-1:0] xs, ys, x_nx, y_nx;
	logic signed [ZW-1:0] da, z_nx;
	logic                 y_pos;

	always_comb begin
		xs    = $signed(d.x) >>> iter;
		ys    = $signed(d.y) >>> iter;
		da    = $signed(ZW'(atan_lut(iter)));
		y_pos = !d.y[CW-1] && (d.y != '0);
		if (y_pos) begin
			x_nx = d.x + ys;
			y_nx = d.y - xs;
			z_nx = d.z + da;
		end else begin
			x_nx = d.x - ys;
			y_nx = d.y + xs;
			z_nx = d.z - da;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= d.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (d.valid) begin
			x_q <= x_nx;
			y_q <= y_nx;
			z_q <= z_nx;
		end
	end

	assign q = '{valid: valid_q, x: x_q, y: y_q, z: z_q};

endmodule

// ===== rtl/ptrk_sqrt_cell.sv =====
// One digit step of the integer square root with its output register.
module ptrk_sqrt_cell import ptrk_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  sqrt_stage_t       d,
	input  logic [STEP_W-1:0] step,
	output sqrt_stage_t       q
);

	logic        valid_q;
	logic [31:0] n_q, r_q;
	logic [31:0] bit_w, n_nx, r_nx;
	logic [32:0] trial;

	always_comb begin
		bit_w = 32'h4000_0000 >> {step, 1'b0};
		trial = {1'b0, d.r} + {1'b0, bit_w};
		if ({1'b0, d.n} >= trial) begin
			n_nx = d.n - trial[31:0];
			r_nx = (d.r >> 1) + bit_w;
		end else begin
			n_nx = d.n;
			r_nx = d.r >> 1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= d.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (d.valid) begin
			n_q <= n_nx;
			r_q <= r_nx;
		end
	end

	assign q = '{valid: valid_q, n: n_q, r: r_q};

endmodule
